FILE: src/nmea_sentence_checker_macros.svh
// ---------------------------------------------------------------------------
// NMEA sentence checker assertion macros
// Clocked assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKER_MACROS_SVH
`define NMEA_SENTENCE_CHECKER_MACROS_SVH

`ifndef SYNTHESIS

// prop is checked at every rising clock edge outside reset
`define NSC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("nmea_sentence_checker: assertion failed");

// cond must never hold outside reset
`define NSC_NEVER(label, clk, rst_n, cond) \
    `NSC_ASSERT(label, clk, rst_n, !(cond))

`else

`define NSC_ASSERT(label, clk, rst_n, prop)
`define NSC_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: src/nsc_pkg.sv
// ---------------------------------------------------------------------------
// nsc_pkg
// Shared types, character codes and helpers for the NMEA sentence checker.
// ---------------------------------------------------------------------------
package nsc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic [7:0] MAX_BODY_LEN_RST = 8'd80;
    localparam logic [7:0] LEN_SATURATED    = 8'hFF;
    localparam logic [1:0] HEX_DIGITS_MAX   = 2'd2;

    typedef enum logic [2:0] {
        KIND_BODY   = 3'd0,
        KIND_OK     = 3'd1,
        KIND_BADSUM = 3'd2,
        KIND_EARLY  = 3'd3,
        KIND_LONG   = 3'd4,
        KIND_TERM   = 3'd5
    } t_kind;

    // one received character held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_rx_item;

    // one result item on its way to the output register
    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data_byte;
        logic [7:0] sentence_length;
        logic [7:0] computed_parity;
    } t_result;

    // {is_hex, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

FILE: src/nsc_in_stage.sv
// ---------------------------------------------------------------------------
// nsc_in_stage
// Input register: holds one received character until the core takes it.
// ---------------------------------------------------------------------------
`include "nmea_sentence_checker_macros.svh"

module nsc_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_take,
    output nsc_pkg::t_rx_item o_item
);
    import nsc_pkg::*;

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_item.valid   = r_valid;
    assign o_item.rx_byte = r_byte;

    `NSC_NEVER(a_take_empty, i_clk, i_rst_n, i_take && !r_valid)
    `NSC_ASSERT(a_full_when_stalled, i_clk, i_rst_n, !o_ready |-> r_valid)

endmodule

FILE: src/nsc_core.sv
// ---------------------------------------------------------------------------
// nsc_core
// Sentence state, parity and checksum tracking; one character per cycle while the result register can accept.
// ---------------------------------------------------------------------------
`include "nmea_sentence_checker_macros.svh"

module nsc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [7:0]        i_cfg_wr_data,
    input  nsc_pkg::t_rx_item i_item,
    input  logic              i_out_ready,
    output logic              o_take,
    output nsc_pkg::t_result  o_result
);
    import nsc_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_BODY = 3'b010,
        PH_SUM  = 3'b100
    } t_phase;

    t_phase     r_phase,  n_phase;
    logic [7:0] r_parity, n_parity;
    logic [7:0] r_len,    n_len;
    logic [7:0] r_hex,    n_hex;
    logic [1:0] r_digits, n_digits;
    logic       r_bad_hex, n_bad_hex;
    logic [7:0] r_max_len;

    logic [7:0] c;
    logic [4:0] nib;
    logic       too_long;
    logic       sum_ok;
    t_result    res;

    assign c        = i_item.rx_byte;
    assign nib      = hex_nibble(c);
    assign o_take   = i_item.valid && i_out_ready;
    assign too_long = (r_len > r_max_len) || (r_len == LEN_SATURATED);
    assign sum_ok   = !r_bad_hex && (r_digits != 2'd0) && (r_hex == r_parity);

    always_comb begin
        n_phase   = r_phase;
        n_parity  = r_parity;
        n_len     = r_len;
        n_hex     = r_hex;
        n_digits  = r_digits;
        n_bad_hex = r_bad_hex;
        res       = '0;
        res.kind  = KIND_BODY;

        case (r_phase)
            PH_BODY: begin
                if (c inside {CH_CR, CH_LF}) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_EARLY;
                end else if (too_long) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_LONG;
                end else begin
                    n_len     = r_len + 8'd1;
                    res.valid = 1'b1;
                    res.data_byte = c;
                    if (c == CH_STAR) begin
                        n_phase   = PH_SUM;
                        n_hex     = '0;
                        n_digits  = '0;
                        n_bad_hex = 1'b0;
                    end else begin
                        n_parity = r_parity ^ c;
                    end
                end
            end
            PH_SUM: begin
                if (c inside {CH_COMMA, CH_STAR}) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_TERM;
                end else if (c inside {CH_CR, CH_LF}) begin
                    res.valid = 1'b1;
                    res.kind  = sum_ok ? KIND_OK : KIND_BADSUM;
                end else if (r_digits < HEX_DIGITS_MAX) begin
                    // extra checksum characters are ignored
                    if (nib[4]) begin
                        n_hex = {r_hex[3:0], nib[3:0]};
                    end else begin
                        n_bad_hex = 1'b1;
                    end
                    n_digits = r_digits + 2'd1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
                if (c == CH_DOLLAR) begin
                    n_phase       = PH_BODY;
                    n_len         = 8'd1;
                    n_parity      = '0;
                    res.valid     = 1'b1;
                    res.data_byte = c;
                end
            end
        endcase

        // any verdict closes the sentence
        if (res.valid && res.kind != KIND_BODY) begin
            res.sentence_length = r_len;
            res.computed_parity = r_parity;
            n_phase             = PH_HUNT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_parity  <= '0;
            r_len     <= '0;
            r_hex     <= '0;
            r_digits  <= '0;
            r_bad_hex <= 1'b0;
        end else if (o_take) begin
            r_phase   <= n_phase;
            r_parity  <= n_parity;
            r_len     <= n_len;
            r_hex     <= n_hex;
            r_digits  <= n_digits;
            r_bad_hex <= n_bad_hex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_BODY_LEN_RST;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    always_comb begin
        o_result       = res;
        o_result.valid = res.valid && o_take;
    end

    `NSC_ASSERT(a_verdict_to_hunt, i_clk, i_rst_n,
        (o_result.valid && o_result.kind != KIND_BODY) |=> r_phase == PH_HUNT)
    `NSC_ASSERT(a_sum_has_len, i_clk, i_rst_n,
        (r_phase == PH_SUM) |-> (r_len >= 8'd2))
    `NSC_ASSERT(a_body_fields_zero, i_clk, i_rst_n,
        (o_result.valid && o_result.kind == KIND_BODY) |->
        (o_result.sentence_length == 8'd0 && o_result.computed_parity == 8'd0))

endmodule

FILE: src/nsc_out_stage.sv
// ---------------------------------------------------------------------------
// nsc_out_stage
// Result register: holds one result item until the receiver takes it.
// ---------------------------------------------------------------------------
`include "nmea_sentence_checker_macros.svh"

module nsc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nsc_pkg::t_result i_result,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output nsc_pkg::t_result o_result
);
    import nsc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_result.valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid && o_ready) begin
            r_res <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    `NSC_NEVER(a_load_when_full, i_clk, i_rst_n,
        i_result.valid && r_valid && !i_ready)

endmodule

FILE: src/nmea_sentence_checker.sv
// ---------------------------------------------------------------------------
// nmea_sentence_checker
// Checks NMEA 0183 sentences byte by byte and reports a checksum verdict.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one received character per item in tdata[7:0].
//   m_axis carries one result item per echoed sentence byte or verdict:
//     tuser = kind (0 body byte, 1 accepted, 2 bad checksum, 3 ended early,
//     4 too long, 5 term after checksum); tdata = data_byte, length, parity.
//   Characters outside a sentence and checksum characters give no item.
//   i_cfg_wr_en / i_cfg_wr_data set the body length limit (reset 80);
//   write it only while no item is in flight.
// Timing:
//   A result item passes through the input register and then the result
//   register before it is offered on m_axis.
//   One character is taken every cycle while the receiver keeps up; the
//   input register and the result register each hold one item.
// Reset and stall:
//   Reset empties both registers and returns to hunting for '$'. When
//   m_axis_tready is low the result register holds and s_axis_tready drops
//   once the input register is also full.
// ---------------------------------------------------------------------------
module nmea_sentence_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [15:8] sentence_length,
                                        // [23:16] computed_parity
    output logic [2:0]  m_axis_tuser    // [2:0] kind
);
    import nsc_pkg::*;

    t_rx_item rx_item;
    t_result  core_res;
    t_result  out_res;
    logic     take;
    logic     out_ready;

    nsc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_take  (take),
        .o_item  (rx_item)
    );

    nsc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (rx_item),
        .i_out_ready   (out_ready),
        .o_take        (take),
        .o_result      (core_res)
    );

    nsc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (core_res),
        .o_ready  (out_ready),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_res)
    );

    assign m_axis_tdata = {out_res.computed_parity, out_res.sentence_length,
                           out_res.data_byte};
    assign m_axis_tuser = out_res.kind;

endmodule

FILE: sim/nmea_sentence_checker_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nmea_sentence_checker_test
// Streams NMEA characters into the checker and scores every echoed byte and
// verdict against a cycle-free model of the sentence scanner. A scripted
// opening covers the corner cases, then random sentences run under several
// body length limits, with random gaps and stalls on both buses.
// ---------------------------------------------------------------------------
module nmea_sentence_checker_test;
    import nsc_pkg::*;

    localparam int DRAIN_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PRESSURE_CYCLES = 300;
    localparam int PRESSURE_AT     = 400;
    localparam int CHAR_BUDGET     = 1870;
    localparam int NUM_PHASES      = 6;

    typedef enum logic [1:0] {
        SCAN_HUNT = 2'd0,
        SCAN_BODY = 2'd1,
        SCAN_SUM  = 2'd2
    } t_scan;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic [7:0] length;
        logic [7:0] parity;
    } t_outcome;

    // one scripted step: a character, or a limit write when is_cfg is set;
    // pinned rows carry their own expected outcome
    typedef struct packed {
        bit         is_cfg;
        logic [7:0] value;
        bit         pinned;
        bit         has;
        t_outcome   res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [7:0] data_byte, [15:8] sentence_length,
                                         // [23:16] computed_parity
    logic [2:0]  m_axis_tuser;           // [2:0] kind

    nmea_sentence_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scanner state mirrored from the block
    t_scan      scan_phase = SCAN_HUNT;
    logic [7:0] body_limit = MAX_BODY_LEN_RST;
    logic [7:0] run_parity = 8'h00;
    logic [7:0] sent_len   = 8'h00;
    logic [7:0] sum_val    = 8'h00;
    logic [1:0] sum_digits = 2'd0;
    bit         sum_bad    = 1'b0;

    t_outcome   pending_results[$];
    int         errors = 0;
    int         chars_sent = 0;
    int         results_seen = 0;
    int         limit_writes = 0;
    int         kind_seen[6] = '{0, 0, 0, 0, 0, 0};
    bit         send_burst = 1'b0;
    bit         recv_burst = 1'b0;
    bit         running = 1'b0;

    t_row script [0:30] = '{
        '{1'b0, 8'h00,     1'b1, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, CH_DOLLAR, 1'b1, 1'b1, '{KIND_BODY,   8'h24, 8'h00, 8'h00}},
        '{1'b0, CH_DOLLAR, 1'b1, 1'b1, '{KIND_BODY,   8'h24, 8'h00, 8'h00}},
        '{1'b0, CH_CR,     1'b1, 1'b1, '{KIND_EARLY,  8'h00, 8'h02, 8'h24}},
        '{1'b0, CH_DOLLAR, 1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, 8'hFF,     1'b1, 1'b1, '{KIND_BODY,   8'hFF, 8'h00, 8'h00}},
        '{1'b0, CH_STAR,   1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, 8'h66,     1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}}, // f
        '{1'b0, 8'h46,     1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}}, // F
        '{1'b0, 8'h5A,     1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}}, // Z, ignored
        '{1'b0, CH_LF,     1'b1, 1'b1, '{KIND_OK,     8'h00, 8'h03, 8'hFF}},
        '{1'b0, CH_DOLLAR, 1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, 8'h0C,     1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, CH_STAR,   1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, 8'h43,     1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}}, // C
        '{1'b0, CH_CR,     1'b1, 1'b1, '{KIND_OK,     8'h00, 8'h03, 8'h0C}},
        '{1'b0, CH_DOLLAR, 1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, CH_STAR,   1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, 8'h47,     1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}}, // G
        '{1'b0, 8'h30,     1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}}, // 0
        '{1'b0, CH_CR,     1'b1, 1'b1, '{KIND_BADSUM, 8'h00, 8'h02, 8'h00}},
        '{1'b0, CH_DOLLAR, 1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, CH_STAR,   1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, CH_LF,     1'b1, 1'b1, '{KIND_BADSUM, 8'h00, 8'h02, 8'h00}},
        '{1'b0, CH_DOLLAR, 1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, CH_STAR,   1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, CH_COMMA,  1'b1, 1'b1, '{KIND_TERM,   8'h00, 8'h02, 8'h00}},
        '{1'b1, 8'h01,     1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, CH_DOLLAR, 1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, 8'h80,     1'b0, 1'b0, '{KIND_BODY,   8'h00, 8'h00, 8'h00}},
        '{1'b0, 8'h7F,     1'b1, 1'b1, '{KIND_LONG,   8'h00, 8'h02, 8'h80}}
    };

    logic [7:0] phase_limits [NUM_PHASES] = '{8'd254, 8'd2, 8'd80, 8'd0, 8'd1, 8'd17};

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    // advance the scanner by one accepted character; returns 1 with r filled
    // when the character yields a result item
    function automatic bit scan_char(input logic [7:0] c, output t_outcome r);
        bit    verdict;
        t_kind vkind;
        int    nib;
        verdict = 1'b0;
        vkind = KIND_OK;
        r = '{KIND_BODY, 8'h00, 8'h00, 8'h00};
        case (scan_phase)
            SCAN_BODY: begin
                if (c == CH_CR || c == CH_LF) begin
                    verdict = 1'b1;
                    vkind = KIND_EARLY;
                end else if (sent_len > body_limit || sent_len == LEN_SATURATED) begin
                    verdict = 1'b1;
                    vkind = KIND_LONG;
                end else begin
                    sent_len = sent_len + 8'd1;
                    if (c == CH_STAR) begin
                        scan_phase = SCAN_SUM;
                        sum_val = 8'h00;
                        sum_digits = 2'd0;
                        sum_bad = 1'b0;
                    end else begin
                        run_parity = run_parity ^ c;
                    end
                    r.data_byte = c;
                    return 1'b1;
                end
            end
            SCAN_SUM: begin
                if (c == CH_COMMA || c == CH_STAR) begin
                    verdict = 1'b1;
                    vkind = KIND_TERM;
                end else if (c == CH_CR || c == CH_LF) begin
                    verdict = 1'b1;
                    vkind = (!sum_bad && sum_digits != 2'd0 && sum_val == run_parity) ?
                            KIND_OK : KIND_BADSUM;
                end else if (sum_digits < HEX_DIGITS_MAX) begin
                    nib = nibble_of(c);
                    if (nib < 0) begin
                        sum_bad = 1'b1;
                    end else begin
                        sum_val = {sum_val[3:0], 4'(nib)};
                    end
                    sum_digits = sum_digits + 2'd1;
                end
            end
            default: begin
                scan_phase = SCAN_HUNT;
                if (c == CH_DOLLAR) begin
                    scan_phase = SCAN_BODY;
                    sent_len = 8'd1;
                    run_parity = 8'h00;
                    r.data_byte = c;
                    return 1'b1;
                end
            end
        endcase
        if (verdict) begin
            r.kind = vkind;
            r.length = sent_len;
            r.parity = run_parity;
            scan_phase = SCAN_HUNT;
        end
        return verdict;
    endfunction

    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 31) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    task automatic send_char(input logic [7:0] c, input bit pinned = 1'b0,
                             input bit pin_has = 1'b0, input t_outcome pin_res = '0);
        int       gap;
        bit       has;
        t_outcome res;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        has = scan_char(c, res);
        if (pinned) begin
            has = pin_has;
            res = pin_res;
        end
        if (has) pending_results.push_back(res);
        chars_sent++;
    endtask

    // write the limit only once the block has drained
    task automatic set_limit(input logic [7:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        body_limit = v;
        limit_writes++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_CR || c == CH_LF || c == CH_STAR);
        return c;
    endfunction

    // anything that neither ends nor terminates a checksum field
    function automatic logic [7:0] filler_char(input bit want_nonhex);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_CR || c == CH_LF || c == CH_COMMA || c == CH_STAR ||
               (want_nonhex && nibble_of(c) >= 0));
        return c;
    endfunction

    task automatic send_sentence();
        int         n;
        int         style;
        int         k;
        logic [7:0] par;
        logic [7:0] c;
        logic [7:0] sum;
        logic [7:0] term;
        term = $urandom_range(0, 1) ? CH_CR : CH_LF;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)));
        end
        // mostly short bodies, now and then one right at the length limit
        if ($urandom_range(0, 15) == 0) begin
            n = int'(body_limit) - 1 + $urandom_range(0, 2);
        end else begin
            n = $urandom_range(0, body_limit < 8'd12 ? int'(body_limit) + 1 : 12);
        end
        send_char(CH_DOLLAR);
        par = 8'h00;
        repeat (n) begin
            c = body_char();
            par = par ^ c;
            send_char(c);
        end
        style = $urandom_range(0, 99);
        if (style < 70) begin
            send_char(CH_STAR);
            sum = ($urandom_range(0, 9) == 0) ? par ^ 8'($urandom_range(1, 255)) : par;
            send_char(hex_char(sum[7:4]));
            send_char(hex_char(sum[3:0]));
            repeat ($urandom_range(0, 2)) send_char(filler_char(1'b0));
            send_char(term);
        end else if (style < 78) begin
            send_char(CH_STAR);
            k = $urandom_range(0, 2);
            if (k == 1) send_char(hex_char(par[3:0]));
            if (k == 2) begin
                send_char(filler_char(1'b1));
                send_char(hex_char(par[3:0]));
            end
            send_char(term);
        end else if (style < 88) begin
            send_char(term);
        end else if (style < 96) begin
            send_char(CH_STAR);
            repeat ($urandom_range(0, 2)) send_char(hex_char(4'($urandom_range(0, 15))));
            send_char($urandom_range(0, 1) ? CH_COMMA : CH_STAR);
        end
        // otherwise leave the sentence open; the next '$' lands in its body
    endtask

    task automatic note_error(input string what, input t_outcome want, input t_outcome got);
        string w;
        string g;
        errors++;
        w = $sformatf("kind %0d data %h len %0d parity %h",
                      want.kind, want.data_byte, want.length, want.parity);
        g = $sformatf("kind %0d data %h len %0d parity %h",
                      got.kind, got.data_byte, got.length, got.parity);
        $display("%0t: %s: expected %s, actual %s", $time, what, w, g);
    endtask

    // result side: random ready gaps, one long hold-off, check each item
    initial begin
        int       gap;
        bit       held;
        t_outcome got;
        t_outcome want;
        held = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && results_seen >= PRESSURE_AT) begin
                held = 1'b1;
                gap = PRESSURE_CYCLES;
            end else begin
                gap = draw_gap(recv_burst);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.kind = t_kind'(m_axis_tuser);
            got.data_byte = m_axis_tdata[7:0];
            got.length = m_axis_tdata[15:8];
            got.parity = m_axis_tdata[23:16];
            results_seen++;
            if (m_axis_tuser <= 3'd5) kind_seen[m_axis_tuser]++;
            if (pending_results.size() == 0) begin
                note_error("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got != want) note_error("result mismatch", want, got);
            end
        end
    end

    // abort when neither bus moves for too long
    always @(posedge i_clk) begin
        int quiet;
        if (!running || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("nmea_sentence_checker_test failed");
                $finish;
            end
        end
    end

    initial begin
        int         phase_end;
        logic [7:0] lim;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                set_limit(script[i].value);
            end else begin
                send_char(script[i].value, script[i].pinned, script[i].has, script[i].res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            lim = (phase_limits[p] == 8'd0) ? 8'($urandom_range(1, 254)) : phase_limits[p];
            set_limit(lim);
            phase_end = chars_sent + CHAR_BUDGET / NUM_PHASES;
            while (chars_sent < phase_end) send_sentence();
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end

        $display("Sent %0d characters, checked %0d results under %0d length limit settings",
                 chars_sent, results_seen, limit_writes);
        $display("Verdicts: %0d ok, %0d bad sum, %0d early, %0d long, %0d stray term",
                 kind_seen[KIND_OK], kind_seen[KIND_BADSUM], kind_seen[KIND_EARLY],
                 kind_seen[KIND_LONG], kind_seen[KIND_TERM]);
        if (errors == 0) begin
            $display("nmea_sentence_checker_test passed");
        end else begin
            $display("nmea_sentence_checker_test failed");
        end
        $finish;
    end

endmodule
